@@ design/cds_pkg.sv @@
// Shared types, constants and month-length function for the calendar date shifter
package cds_pkg;

  // Default width of the signed day offset
  localparam int DELTA_BITS_DEF = 17;

  // Supported year window and its internal offset encoding
  localparam int YEAR_MIN   = 2000;
  localparam int YEAR_MAX   = 2099;
  localparam int YOFF_W     = 7;
  localparam int YOFF_LAST  = YEAR_MAX - YEAR_MIN;
  localparam int MONTHS     = 12;
  localparam int LEAP_FEB   = 29;

  // Field widths fixed by the interface
  localparam int YEAR_IN_W  = 14;
  localparam int MD_IN_W    = 7;
  localparam int YEAR_OUT_W = 12;
  localparam int MON_W      = 4;
  localparam int DAY_W      = 5;

  // Month lengths in a common year, January first
  localparam logic [DAY_W-1:0] MONTH_LEN [MONTHS] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DATE = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;
    logic    step;
    logic    finish;
    status_t code;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic start_ok;
    logic left_zero;
    logic left_neg;
    logic at_end;
    logic at_begin;
  } dp_stat_t;

  // Days in a month; zero for a month code outside 1..12
  function automatic logic [DAY_W-1:0] month_days(input logic leap, input logic [MON_W-1:0] mon);
    logic [DAY_W-1:0] len;
    len = '0;
    if (mon >= MON_W'(1) && mon <= MON_W'(MONTHS)) begin
      len = MONTH_LEN[mon - MON_W'(1)];
      if (mon == MON_W'(2) && leap) begin
        len = DAY_W'(LEAP_FEB);
      end
    end
    return len;
  endfunction

endpackage

@@ design/cds_ctrl.sv @@
// Controller state machine for the calendar date shifter
module cds_ctrl
  import cds_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        priority if (!stat.start_ok) begin
          cmd.finish = 1'b1;
          cmd.code   = ST_BAD_DATE;
          state_nxt  = S_DONE;
        end else if (stat.left_zero) begin
          cmd.finish = 1'b1;
          cmd.code   = ST_OK;
          state_nxt  = S_DONE;
        end else if ((!stat.left_neg && stat.at_end) || (stat.left_neg && stat.at_begin)) begin
          // next day would fall outside the year window
          cmd.finish = 1'b1;
          cmd.code   = ST_RANGE;
          state_nxt  = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/cds_dpath.sv @@
// Datapath: start date check, day stepper and result register
module cds_dpath
  import cds_pkg::*;
#(
  parameter int DELTA_BITS = DELTA_BITS_DEF
) (
  input  logic                         clk,
  input  logic [YEAR_IN_W-1:0]         in_start_year,
  input  logic [MD_IN_W-1:0]           in_start_month,
  input  logic [MD_IN_W-1:0]           in_start_day,
  input  logic signed [DELTA_BITS-1:0] in_delta_days,
  input  dp_cmd_t                      cmd,
  output dp_stat_t                     stat,
  output logic [1:0]                   out_status,
  output logic [YEAR_OUT_W-1:0]        out_year,
  output logic [MON_W-1:0]             out_month,
  output logic [DAY_W-1:0]             out_day
);

  logic [YOFF_W-1:0]            yoff_r;
  logic [MON_W-1:0]             mon_r;
  logic [DAY_W-1:0]             day_r;
  logic signed [DELTA_BITS-1:0] left_r;
  logic                         start_ok_r;
  status_t                      status_r;

  logic             year_ok, mon_ok, day_ok, in_leap;
  logic [DAY_W-1:0] in_mdays;
  logic             cur_leap;
  logic [DAY_W-1:0] cur_mdays, prev_mdays;
  logic [MON_W-1:0] prev_mon;

  // Start date check on the incoming fields
  always_comb begin
    year_ok  = (in_start_year >= YEAR_IN_W'(YEAR_MIN)) && (in_start_year <= YEAR_IN_W'(YEAR_MAX));
    mon_ok   = (in_start_month >= MD_IN_W'(1)) && (in_start_month <= MD_IN_W'(MONTHS));
    // within the window, every year divisible by four is a leap year (2000 included)
    in_leap  = (in_start_year[1:0] == 2'b00);
    in_mdays = month_days(in_leap, in_start_month[MON_W-1:0]);
    day_ok   = (in_start_day != '0) && (in_start_day <= MD_IN_W'(in_mdays));
  end

  // Month lengths around the current date
  always_comb begin
    cur_leap   = (yoff_r[1:0] == 2'b00);
    cur_mdays  = month_days(cur_leap, mon_r);
    prev_mon   = (mon_r == MON_W'(1)) ? MON_W'(MONTHS) : mon_r - MON_W'(1);
    prev_mdays = month_days(cur_leap, prev_mon);
  end

  // Status towards the controller
  always_comb begin
    stat.start_ok  = start_ok_r;
    stat.left_zero = (left_r == '0);
    stat.left_neg  = left_r[DELTA_BITS-1];
    stat.at_end    = (yoff_r == YOFF_W'(YOFF_LAST)) && (mon_r == MON_W'(MONTHS)) &&
                     (day_r == DAY_W'(31));
    stat.at_begin  = (yoff_r == '0) && (mon_r == MON_W'(1)) && (day_r == DAY_W'(1));
  end

  // Date, offset and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      start_ok_r <= year_ok && mon_ok && day_ok;
      yoff_r     <= YOFF_W'(in_start_year - YEAR_IN_W'(YEAR_MIN));
      mon_r      <= in_start_month[MON_W-1:0];
      day_r      <= in_start_day[DAY_W-1:0];
      left_r     <= in_delta_days;
    end else if (cmd.step) begin
      if (!left_r[DELTA_BITS-1]) begin
        // one day forward
        left_r <= left_r - DELTA_BITS'(1);
        if (day_r == cur_mdays) begin
          day_r <= DAY_W'(1);
          if (mon_r == MON_W'(MONTHS)) begin
            mon_r  <= MON_W'(1);
            yoff_r <= yoff_r + YOFF_W'(1);
          end else begin
            mon_r <= mon_r + MON_W'(1);
          end
        end else begin
          day_r <= day_r + DAY_W'(1);
        end
      end else begin
        // one day back
        left_r <= left_r + DELTA_BITS'(1);
        if (day_r == DAY_W'(1)) begin
          mon_r <= prev_mon;
          day_r <= prev_mdays;
          if (mon_r == MON_W'(1)) begin
            yoff_r <= yoff_r - YOFF_W'(1);
          end
        end else begin
          day_r <= day_r - DAY_W'(1);
        end
      end
    end
    if (cmd.finish) begin
      status_r <= cmd.code;
    end
  end

  // Result fields, zero unless the shift succeeded
  always_comb begin
    out_status = status_r;
    out_year   = '0;
    out_month  = '0;
    out_day    = '0;
    if (status_r == ST_OK) begin
      out_year  = YEAR_OUT_W'(YEAR_MIN) + YEAR_OUT_W'(yoff_r);
      out_month = mon_r;
      out_day   = day_r;
    end
  end

endmodule

@@ design/calendar_date_shift.sv @@
// Top level of the calendar date shifter: controller plus datapath
//
//   Channel  Handshake            Payload
//   in_      in_valid/in_ready    in_start_year, in_start_month, in_start_day, in_delta_days
//   out_     out_valid/out_ready  out_status, out_year, out_month, out_day
//
// One item at a time. A running item is stepped one day per cycle until its offset is
// used up; a shift that leaves the year window stops at the window edge. An invalid
// start date or a zero offset finishes without stepping. A result is held until its
// transfer out, and the next input is taken the cycle after. Reset (rst_n, synchronous)
// returns the controller to idle; no memory needs clearing.
module calendar_date_shift
  import cds_pkg::*;
#(
  parameter int DELTA_BITS = DELTA_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [YEAR_IN_W-1:0]         in_start_year,
  input  logic [MD_IN_W-1:0]           in_start_month,
  input  logic [MD_IN_W-1:0]           in_start_day,
  input  logic signed [DELTA_BITS-1:0] in_delta_days,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [YEAR_OUT_W-1:0]        out_year,
  output logic [MON_W-1:0]             out_month,
  output logic [DAY_W-1:0]             out_day
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  cds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cds_dpath #(
    .DELTA_BITS (DELTA_BITS)
  ) u_dpath (
    .clk            (clk),
    .in_start_year  (in_start_year),
    .in_start_month (in_start_month),
    .in_start_day   (in_start_day),
    .in_delta_days  (in_delta_days),
    .cmd            (cmd),
    .stat           (stat),
    .out_status     (out_status),
    .out_year       (out_year),
    .out_month      (out_month),
    .out_day        (out_day)
  );

endmodule
